// File: rtl/minv_pkg.sv
package minv_pkg;

	// Fixed field widths of the item ports
	localparam int IN_W  = 32;
	localparam int OUT_W = 32;

	// Status from the shared divider to the sequencer
	typedef struct packed {
		logic bit_vld;  // a quotient bit is produced this cycle
		logic qbit;     // that quotient bit, most significant first
		logic done;     // remainder is final
	} div_stat_t;

endpackage

// File: rtl/minv_div.sv
module minv_div import minv_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output div_stat_t        stat,
	output logic [WIDTH-1:0] remainder
);

	localparam int CNT_W = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   diff;
	logic             ge;

	// Trial subtraction of one restoring step
	always_comb begin
		shifted = {rem_q, quo_q[WIDTH-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = !diff[WIDTH];
	end

	// Control: load on start, count down one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift dividend bits in, quotient bits out
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], ge};
		end
	end

	assign stat.bit_vld = busy_q;
	assign stat.qbit    = ge;
	assign stat.done    = done_q;
	assign remainder    = rem_q;

endmodule

// File: rtl/modular_inverse_unit.sv
// Modular inverse by the extended Euclidean algorithm.
// Input channel (in_valid / in_stall) carries value and modulus; the unit
// reduces value modulo modulus, then runs quotient/remainder steps while it
// tracks the signed coefficient of value. Output channel (out_valid /
// out_stall) returns inverse and has_inverse, one result item per item.
// Every division runs on one shared restoring divider, one quotient bit per
// cycle; the coefficient product q * coef is built bit by bit beside it.
// The work runs as the first reduction, then one division per Euclid step,
// then the final step, the fix step if an inverse exists, and the put step.
// A zero modulus skips the divider and goes straight to the put step.
// One item is worked on at a time; in_stall is high from acceptance until the
// result is placed in the output register. A new item may be accepted while a
// result still waits there; the next result waits while out_stall is high.
// Reset clears the sequencer and output valid; no item is in flight after it.
module modular_inverse_unit import minv_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [IN_W-1:0]  value,
	input  logic [IN_W-1:0]  modulus,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [OUT_W-1:0] inverse,
	output logic             has_inverse
);

	localparam int CW = WIDTH + 2;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_REDUCE = 3'd1;
	localparam logic [2:0] S_CHECK  = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_FINAL  = 3'd4;
	localparam logic [2:0] S_FIX    = 3'd5;
	localparam logic [2:0] S_PUT    = 3'd6;

	logic [2:0]       state_q;
	logic [WIDTH-1:0] mod_q;
	logic [WIDTH-1:0] rp_q;
	logic [WIDTH-1:0] rc_q;
	logic [CW-1:0]    cp_q;
	logic [CW-1:0]    cc_q;
	logic [CW-1:0]    prod_q;
	logic             neg_q;
	logic [WIDTH-1:0] res_inv_q;
	logic             res_ok_q;
	logic             out_valid_q;
	logic [OUT_W-1:0] inverse_q;
	logic             has_inverse_q;

	logic [WIDTH-1:0] val_in;
	logic [WIDTH-1:0] mod_in;
	logic             accept;
	logic             div_start;
	logic [WIDTH-1:0] div_dividend;
	logic [WIDTH-1:0] div_divisor;
	div_stat_t        div_stat;
	logic [WIDTH-1:0] div_rem;
	logic             out_free;
	logic [CW-1:0]    mag;
	logic [CW-1:0]    red;

	// Cut inputs to the datapath width
	assign val_in = WIDTH'(value);
	assign mod_in = WIDTH'(modulus);

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Start the divider for the first reduction or a Euclid step
	always_comb begin
		div_start    = 1'b0;
		div_dividend = rp_q;
		div_divisor  = rc_q;
		if (state_q == S_IDLE) begin
			div_start    = in_valid && (mod_in != '0);
			div_dividend = val_in;
			div_divisor  = mod_in;
		end else if (state_q == S_CHECK) begin
			div_start = (rc_q != '0);
		end
	end

	minv_div #(
		.WIDTH(WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.stat      (div_stat),
		.remainder (div_rem)
	);

	// Fold the signed coefficient into 0..modulus-1 magnitude
	always_comb begin
		mag = cp_q[CW-1] ? (CW'(0) - cp_q) : cp_q;
		red = (mag >= {2'b00, mod_q}) ? (mag - {2'b00, mod_q}) : mag;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (mod_in == '0) ? S_PUT : S_REDUCE;
					end
				end
				S_REDUCE: begin
					if (div_stat.done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= (rc_q == '0) ? S_FINAL : S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_CHECK;
					end
				end
				S_FINAL: begin
					state_q <= (rp_q == WIDTH'(1)) ? S_FIX : S_PUT;
				end
				S_FIX: begin
					state_q <= S_PUT;
				end
				S_PUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Euclid datapath: remainders, coefficients and the running product
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mod_q     <= mod_in;
				rp_q      <= mod_in;
				res_inv_q <= '0;
				res_ok_q  <= 1'b0;
			end
			S_REDUCE: begin
				if (div_stat.done) begin
					rc_q <= div_rem;
					cp_q <= '0;
					cc_q <= CW'(1);
				end
			end
			S_CHECK: begin
				prod_q <= '0;
			end
			S_DIV: begin
				if (div_stat.bit_vld) begin
					prod_q <= {prod_q[CW-2:0], 1'b0} + (div_stat.qbit ? cc_q : '0);
				end
				if (div_stat.done) begin
					rp_q <= rc_q;
					rc_q <= div_rem;
					cp_q <= cc_q;
					cc_q <= cp_q - prod_q;
				end
			end
			S_FINAL: begin
				prod_q <= red;
				neg_q  <= cp_q[CW-1];
			end
			S_FIX: begin
				res_ok_q  <= 1'b1;
				res_inv_q <= (neg_q && (prod_q != '0)) ?
					(mod_q - prod_q[WIDTH-1:0]) : prod_q[WIDTH-1:0];
			end
			default: begin
			end
		endcase
	end

	// Output register: load when free, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_PUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PUT && out_free) begin
			inverse_q     <= OUT_W'(res_inv_q);
			has_inverse_q <= res_ok_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign inverse     = inverse_q;
	assign has_inverse = has_inverse_q;

	// The divider is never restarted while it still produces bits
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.bit_vld)
		else $error("divider restarted while busy");

	// A finished division arrives only where the sequencer waits for it
	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_REDUCE || state_q == S_DIV))
		else $error("division finished in an unexpected state");

	// A missing inverse is always reported as zero
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_inverse) |-> (inverse == '0))
		else $error("nonzero inverse without has_inverse");

	// A result is only loaded once the sequencer reaches the put step
	a_load_put: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == S_PUT))
		else $error("output loaded outside the put step");

endmodule
